@@ design/euler_zyx_to_unit_vector_defines.svh @@
// assertion macros used by the top-level design file
`ifndef EULER_ZYX_TO_UNIT_VECTOR_DEFINES_SVH
`define EULER_ZYX_TO_UNIT_VECTOR_DEFINES_SVH

// implication checked on every edge outside reset
`define EZV_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// implication with the right side checked in the next cycle, outside reset
`define EZV_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

@@ design/ezv_pkg.sv @@
package ezv_pkg;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int OUT_FRAC_BITS   = 14;
   localparam int TRIG_STAGES     = 16;
   localparam int CORDIC_STAGES   = (TRIG_STAGES < 32) ? TRIG_STAGES : 32;
   localparam int ANG_W           = 16;
   localparam int OUT_W           = 16;
   localparam int Q_W             = 34;
   localparam int Z_W             = 34;
   localparam int PROD_W          = 2 * Q_W;
   localparam int OUT_SH          = 30 - OUT_FRAC_BITS;
   // 2^(32-frac)/360 is 2^PHASE_SH/45
   localparam int PHASE_SH        = 29 - ANGLE_FRAC_BITS;

   localparam logic signed [Q_W-1:0] CORDIC_X0 = Q_W'(652032874);

   typedef logic signed [Q_W-1:0] q_type;
   typedef logic signed [Z_W-1:0] z_type;

   typedef struct packed {
      q_type x;
      q_type y;
      z_type z;
   } rot_type;

   typedef struct packed {
      rot_type [2:0] rot;
      logic    [2:0] flip;
   } lane_type;

   function automatic z_type atan_turn(input int i);
      unique case (i)
         0: atan_turn = Z_W'(536870912);
         1: atan_turn = Z_W'(316933406);
         2: atan_turn = Z_W'(167458907);
         3: atan_turn = Z_W'(85004756);
         4: atan_turn = Z_W'(42667331);
         5: atan_turn = Z_W'(21354465);
         6: atan_turn = Z_W'(10679838);
         7: atan_turn = Z_W'(5340245);
         8: atan_turn = Z_W'(2670163);
         9: atan_turn = Z_W'(1335087);
         10: atan_turn = Z_W'(667544);
         11: atan_turn = Z_W'(333772);
         12: atan_turn = Z_W'(166886);
         13: atan_turn = Z_W'(83443);
         14: atan_turn = Z_W'(41722);
         15: atan_turn = Z_W'(20861);
         16: atan_turn = Z_W'(10430);
         17: atan_turn = Z_W'(5215);
         18: atan_turn = Z_W'(2608);
         19: atan_turn = Z_W'(1304);
         20: atan_turn = Z_W'(652);
         21: atan_turn = Z_W'(326);
         22: atan_turn = Z_W'(163);
         23: atan_turn = Z_W'(81);
         24: atan_turn = Z_W'(41);
         25: atan_turn = Z_W'(20);
         26: atan_turn = Z_W'(10);
         27: atan_turn = Z_W'(5);
         28: atan_turn = Z_W'(3);
         29: atan_turn = Z_W'(1);
         30: atan_turn = Z_W'(1);
         default: atan_turn = '0;
      endcase
   endfunction

   // binary angle of the remainder after whole steps of 45, rounded half up
   function automatic logic [31:0] phase_frac(input logic [5:0] b);
      phase_frac = '0;
      for (int j = 0; j < 45; j++)
         if (b == 6'(j)) phase_frac = 32'(((64'(j) << PHASE_SH) + 64'd22) / 64'd45);
   endfunction

   // q4.30 product rounded half up
   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'(b) + PROD_W'(64'sd536870912);
      qmul = q_type'(p >>> 30);
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input q_type v);
      logic signed [Q_W:0] r;
      r = (Q_W+1)'(v);
      if (OUT_SH > 0) r = (r + ((Q_W+1)'(1) <<< (OUT_SH - 1))) >>> OUT_SH;
      if (r > ((Q_W+1)'(1) <<< OUT_FRAC_BITS)) r = (Q_W+1)'(1) <<< OUT_FRAC_BITS;
      if (r < -((Q_W+1)'(1) <<< OUT_FRAC_BITS)) r = -((Q_W+1)'(1) <<< OUT_FRAC_BITS);
      to_out = r[OUT_W-1:0];
   endfunction
endpackage

@@ design/ezv_cordic_cell.sv @@
// one cordic micro-rotation on all three angles, plus pipeline valid
module ezv_cordic_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [4:0]             shift,
   input  logic                   advance,
   input  logic                   valid_in,
   input  ezv_pkg::lane_type      lane_in,
   output logic                   valid_out,
   output ezv_pkg::lane_type      lane_out
);
   ezv_pkg::lane_type lane_in_c, lane_ff;
   logic valid_ff;
   ezv_pkg::z_type turn;

   always_comb begin
      turn = ezv_pkg::atan_turn(int'(shift));
      lane_in_c = lane_in;
      for (int k = 0; k < 3; k++) begin
         if (!lane_in.rot[k].z[ezv_pkg::Z_W-1]) begin
            lane_in_c.rot[k].x = lane_in.rot[k].x - (lane_in.rot[k].y >>> shift);
            lane_in_c.rot[k].y = lane_in.rot[k].y + (lane_in.rot[k].x >>> shift);
            lane_in_c.rot[k].z = lane_in.rot[k].z - turn;
         end else begin
            lane_in_c.rot[k].x = lane_in.rot[k].x + (lane_in.rot[k].y >>> shift);
            lane_in_c.rot[k].y = lane_in.rot[k].y - (lane_in.rot[k].x >>> shift);
            lane_in_c.rot[k].z = lane_in.rot[k].z + turn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (advance) valid_ff <= valid_in;
      if (advance) lane_ff <= lane_in_c;
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;
endmodule

@@ design/euler_zyx_to_unit_vector.sv @@
// Angles to pointing direction: one beat in and one beat out per clock once the
// pipeline is full. The stages are one phase-conversion register, one cordic
// cell per micro-rotation, then two product registers, a sum register and the
// output register; the whole pipeline stalls when the output register is full
// and not taken.
`include "euler_zyx_to_unit_vector_defines.svh"
module euler_zyx_to_unit_vector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // azimuth_deg [15:0], elevation_deg [31:16], roll_deg [47:32]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
   output logic [47:0] rsp_tdata
);
   localparam int N = ezv_pkg::CORDIC_STAGES;

   logic advance;
   logic [N:0] v;
   ezv_pkg::lane_type [N:0] lane;
   ezv_pkg::lane_type lane0_in, lane0_ff;
   logic v0_ff;

   logic out_valid_ff;
   logic [47:0] out_data_ff;
   logic v1_ff, v2_ff, v3_ff;
   ezv_pkg::q_type sa, ca, se, ce, sr, cr;
   ezv_pkg::q_type p_cs_ff, p_ss_ff, p_sr_ff, p_cr_ff, p_ecr_ff, cr_ff;
   ezv_pkg::q_type t_x_ff, t_y_ff, t_sr_ff, t_cr_ff, t_z_ff;
   ezv_pkg::q_type vx_ff, vy_ff, vz_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // degrees to binary angle, fold to the right half plane
   // magnitude split into whole steps of 45 and a remainder looked up
   always_comb begin
      logic [15:0] raw, mag;
      logic [31:0] prod;
      logic [9:0]  quo;
      logic [5:0]  rem;
      logic [31:0] q, ph;
      lane0_in = '0;
      for (int k = 0; k < 3; k++) begin
         raw  = req_tdata[16*k +: 16];
         mag  = raw[15] ? (16'd0 - raw) : raw;
         // exact quotient by 45 for magnitudes up to half the 16-bit range
         prod = 32'(mag) * 32'd46604;
         quo  = prod[30:21];
         rem  = 6'(mag - 16'(quo) * 16'd45);
         q    = 32'({22'd0, quo} << ezv_pkg::PHASE_SH) + ezv_pkg::phase_frac(rem);
         ph   = raw[15] ? (32'd0 - q) : q;
         lane0_in.flip[k] = ph[31] ^ ph[30];
         if (ph[31] ^ ph[30]) ph = ph + 32'h8000_0000;
         lane0_in.rot[k].x = ezv_pkg::CORDIC_X0;
         lane0_in.rot[k].y = '0;
         lane0_in.rot[k].z = ezv_pkg::z_type'(signed'(ph));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (advance) v0_ff <= req_tvalid;
      if (advance) lane0_ff <= lane0_in;
   end

   assign v[0]    = v0_ff;
   assign lane[0] = lane0_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      ezv_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (5'(i)),
         .advance  (advance),
         .valid_in (v[i]),
         .lane_in  (lane[i]),
         .valid_out(v[i+1]),
         .lane_out (lane[i+1])
      );
   end

   always_comb begin
      ca = lane[N].flip[0] ? -lane[N].rot[0].x : lane[N].rot[0].x;
      sa = lane[N].flip[0] ? -lane[N].rot[0].y : lane[N].rot[0].y;
      ce = lane[N].flip[1] ? -lane[N].rot[1].x : lane[N].rot[1].x;
      se = lane[N].flip[1] ? -lane[N].rot[1].y : lane[N].rot[1].y;
      cr = lane[N].flip[2] ? -lane[N].rot[2].x : lane[N].rot[2].x;
      sr = lane[N].flip[2] ? -lane[N].rot[2].y : lane[N].rot[2].y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v[N]; v2_ff <= v1_ff; v3_ff <= v2_ff; out_valid_ff <= v3_ff;
      end
      if (advance) begin
         p_cs_ff  <= ezv_pkg::qmul(ca, se);
         p_ss_ff  <= ezv_pkg::qmul(sa, se);
         p_sr_ff  <= ezv_pkg::qmul(sa, sr);
         p_cr_ff  <= ezv_pkg::qmul(ca, sr);
         p_ecr_ff <= ezv_pkg::qmul(ce, cr);
         cr_ff    <= cr;
         t_x_ff   <= ezv_pkg::qmul(p_cs_ff, cr_ff);
         t_y_ff   <= ezv_pkg::qmul(p_ss_ff, cr_ff);
         t_sr_ff  <= p_sr_ff;
         t_cr_ff  <= p_cr_ff;
         t_z_ff   <= p_ecr_ff;
         vx_ff    <= -(t_x_ff + t_sr_ff);
         vy_ff    <= -(t_y_ff - t_cr_ff);
         vz_ff    <= -t_z_ff;
         out_data_ff <= {ezv_pkg::to_out(vz_ff), ezv_pkg::to_out(vy_ff),
                         ezv_pkg::to_out(vx_ff)};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `EZV_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped while stalled")
   `EZV_ASSERT_IMPL(a_ready, clock, reset, !rsp_tvalid, req_tready, "input blocked with empty output")
   `EZV_ASSERT_NEXT(a_flow, clock, reset, v3_ff && advance, rsp_tvalid, "pipeline lost a beat")
endmodule
